[rtl/core/lru_cache_pkg.sv]
// Package for the LRU set-associative write-through cache block.
// Holds sizes, payload structs and the sequencer state type; no dependencies.
`default_nettype none
package lru_cache_pkg;
	localparam int ADDR_BITS = 16;
	localparam int SET_BITS  = 10;
	localparam int WAYS      = 16;
	localparam int MAX_BYTES = 8;
	localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int WCNT_W    = $clog2(WAYS + 1);

	localparam logic [1:0] REG_LOG_BLOCK = 2'd0;
	localparam logic [1:0] REG_LOG_SETS  = 2'd1;
	localparam logic [1:0] REG_WAYS      = 2'd2;

	typedef struct packed {
		logic        cmd;
		logic [15:0] address;
		logic [3:0]  access_size;
		logic [63:0] store_data;
	} req_t;

	typedef struct packed {
		logic        was_store;
		logic        hit;
		logic [63:0] load_data;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] tag;
		logic                 valid;
	} way_t;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_TAGRD, ST_TAGUPD, ST_BYTES, ST_DONE
	} state_t;
endpackage
`default_nettype wire

[rtl/core/lru_cache_data.sv]
// Byte-wide backing memory with a single read/write port; the top level
// drives its clearing sweep through the same port. Depends on lru_cache_pkg.
`default_nettype none
module lru_cache_data (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [lru_cache_pkg::ADDR_BITS-1:0]   addr,
	input  wire logic [7:0]                            wdata,
	output logic [7:0]                                 rdata
);
	logic [7:0] mem [0:(1 << lru_cache_pkg::ADDR_BITS)-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

[rtl/core/lru_cache_tags.sv]
// Tag memory: one row per set, each row holds every way with its valid bit.
// Depends on lru_cache_pkg.
`default_nettype none
module lru_cache_tags (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [lru_cache_pkg::SET_BITS-1:0]    addr,
	input  wire lru_cache_pkg::way_t                   wrow [lru_cache_pkg::WAYS],
	output lru_cache_pkg::way_t                        rrow [lru_cache_pkg::WAYS]
);
	lru_cache_pkg::way_t mem [0:(1 << lru_cache_pkg::SET_BITS)-1][lru_cache_pkg::WAYS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wrow;
		end
		rrow <= mem[addr];
	end
endmodule
`default_nettype wire

[rtl/core/lru_set_assoc_cache_write_through.sv]
// Top level of the LRU set-associative write-through cache model block.
// Depends on lru_cache_pkg, lru_cache_tags and lru_cache_data.
//
// Usage: requests arrive on in_valid/in_ready carrying cmd, address,
// access_size and store_data. Each request produces exactly one response on
// out_valid/out_ready. Configuration writes use cfg_valid/cfg_ready with a
// register index and data, and are only issued while the block is idle.
//
// Each request is handled alone. The tag row of the set is read from the
// tag memory, then searched and, on a hit or a load, rewritten in LRU order;
// then the bytes go through the single-port backing memory one per cycle,
// with the size clipped to 8 bytes, and a load waits for its last byte read
// to return. The response is then offered in the done state; with a ready
// receiver the block passes through done, then idle, where it takes the
// next request.
//
// After reset the block sweeps the tag memory (clearing valid bits) and the
// backing memory (writing zero); both run together, and in_ready stays low
// until the backing memory sweep ends. Configuration writes are taken
// throughout. The response sits in an output register; a stalled receiver
// holds the block in the done state until it is taken.
`default_nettype none
module lru_set_assoc_cache_write_through (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire lru_cache_pkg::req_t   in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output lru_cache_pkg::rsp_t        out_data,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [4:0]            cfg_data
);
	localparam int AB = lru_cache_pkg::ADDR_BITS;
	localparam int SB = lru_cache_pkg::SET_BITS;
	localparam int NW = lru_cache_pkg::WAYS;

	lru_cache_pkg::state_t state_q, state_d;
	logic [2:0] lb_q;
	logic [3:0] ls_q;
	logic [4:0] nw_q;

	lru_cache_pkg::req_t req_q;
	logic [AB-1:0] clr_q;
	logic [3:0] bcnt_q;
	logic rd_pend_q;
	logic hit_q;
	logic [63:0] ld_q;

	// Effective configuration.
	logic [3:0] ls_eff;
	logic [lru_cache_pkg::WCNT_W-1:0] nw_eff;
	logic [3:0] size_eff;
	always_comb begin
		ls_eff = (ls_q > 4'(SB)) ? 4'(SB) : ls_q;
		if (nw_q == 5'd0) begin
			nw_eff = lru_cache_pkg::WCNT_W'(1);
		end else if (32'(nw_q) > NW) begin
			nw_eff = lru_cache_pkg::WCNT_W'(NW);
		end else begin
			nw_eff = lru_cache_pkg::WCNT_W'(nw_q);
		end
		size_eff = (req_q.access_size > 4'(lru_cache_pkg::MAX_BYTES))
			? 4'(lru_cache_pkg::MAX_BYTES) : req_q.access_size;
	end

	logic [AB-1:0] addr_m;
	logic [AB-1:0] tag;
	logic [SB-1:0] set_idx;
	always_comb begin
		addr_m  = req_q.address[AB-1:0];
		tag     = addr_m >> (5'(lb_q) + 5'(ls_eff));
		set_idx = SB'((addr_m >> lb_q) & AB'((32'd1 << ls_eff) - 32'd1));
	end

	// Tag memory access.
	lru_cache_pkg::way_t rrow [NW];
	lru_cache_pkg::way_t wrow [NW];
	logic tag_we;
	logic [SB-1:0] tag_addr;

	logic found;
	logic [lru_cache_pkg::WAY_W-1:0] fidx;
	logic [lru_cache_pkg::WAY_W-1:0] from;
	logic do_promote;
	always_comb begin
		found = 1'b0;
		fidx  = '0;
		for (int w = NW - 1; w >= 0; w--) begin
			if (w < 32'(nw_eff) && rrow[w].valid && rrow[w].tag == tag) begin
				found = 1'b1;
				fidx  = lru_cache_pkg::WAY_W'(w);
			end
		end
		from = found ? fidx : lru_cache_pkg::WAY_W'(32'(nw_eff) - 1);
		do_promote = found || !req_q.cmd;
		for (int w = 0; w < NW; w++) begin
			if (w == 0) begin
				wrow[w] = '{tag: tag, valid: 1'b1};
			end else if (w <= 32'(from)) begin
				wrow[w] = rrow[w-1];
			end else begin
				wrow[w] = rrow[w];
			end
		end
		if (state_q == lru_cache_pkg::ST_CLEAR) begin
			for (int w = 0; w < NW; w++) begin
				wrow[w] = '{tag: '0, valid: 1'b0};
			end
		end
	end

	assign tag_addr = (state_q == lru_cache_pkg::ST_CLEAR) ? clr_q[SB-1:0] : set_idx;
	assign tag_we = (state_q == lru_cache_pkg::ST_CLEAR && clr_q < AB'(1 << SB))
		|| (state_q == lru_cache_pkg::ST_TAGUPD && do_promote);

	lru_cache_tags u_tags (
		.clk  (clk),
		.we   (tag_we),
		.addr (tag_addr),
		.wrow (wrow),
		.rrow (rrow)
	);

	// Backing memory: one byte per cycle.
	logic mem_we;
	logic [AB-1:0] mem_addr;
	logic [7:0] mem_wdata;
	logic [7:0] mem_rdata;
	logic in_bytes;
	assign in_bytes = (state_q == lru_cache_pkg::ST_BYTES) && (bcnt_q < size_eff);
	always_comb begin
		if (state_q == lru_cache_pkg::ST_CLEAR) begin
			mem_addr  = clr_q;
			mem_wdata = 8'd0;
			mem_we    = 1'b1;
		end else begin
			mem_addr  = addr_m + AB'(bcnt_q);
			mem_wdata = req_q.store_data[{bcnt_q[2:0], 3'b000} +: 8];
			mem_we    = in_bytes && req_q.cmd;
		end
	end

	lru_cache_data u_data (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lru_cache_pkg::ST_CLEAR: begin
				if (clr_q == {AB{1'b1}}) state_d = lru_cache_pkg::ST_IDLE;
			end
			lru_cache_pkg::ST_IDLE: begin
				if (in_valid) state_d = lru_cache_pkg::ST_TAGRD;
			end
			lru_cache_pkg::ST_TAGRD:  state_d = lru_cache_pkg::ST_TAGUPD;
			lru_cache_pkg::ST_TAGUPD: state_d = lru_cache_pkg::ST_BYTES;
			lru_cache_pkg::ST_BYTES: begin
				if (!in_bytes && !rd_pend_q) state_d = lru_cache_pkg::ST_DONE;
			end
			lru_cache_pkg::ST_DONE: begin
				if (out_ready) state_d = lru_cache_pkg::ST_IDLE;
			end
			default: state_d = lru_cache_pkg::ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		in_ready  = (state_q == lru_cache_pkg::ST_IDLE);
		out_valid = (state_q == lru_cache_pkg::ST_DONE);
		cfg_ready = 1'b1;
		out_data.was_store = req_q.cmd;
		out_data.hit       = hit_q;
		out_data.load_data = req_q.cmd ? 64'd0 : ld_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lru_cache_pkg::ST_CLEAR;
			clr_q     <= '0;
			lb_q      <= 3'd5;
			ls_q      <= 4'd6;
			nw_q      <= 5'd4;
			bcnt_q    <= '0;
			rd_pend_q <= 1'b0;
			hit_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lru_cache_pkg::ST_CLEAR) clr_q <= clr_q + AB'(1);
			if (cfg_valid) begin
				unique case (cfg_index)
					lru_cache_pkg::REG_LOG_BLOCK: lb_q <= cfg_data[2:0];
					lru_cache_pkg::REG_LOG_SETS:  ls_q <= cfg_data[3:0];
					lru_cache_pkg::REG_WAYS:      nw_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == lru_cache_pkg::ST_TAGUPD) begin
				hit_q  <= found;
				bcnt_q <= '0;
			end
			if (state_q == lru_cache_pkg::ST_BYTES) begin
				rd_pend_q <= in_bytes && !req_q.cmd;
				if (in_bytes) bcnt_q <= bcnt_q + 4'd1;
			end else begin
				rd_pend_q <= 1'b0;
			end
		end
	end

	// Request and load data registers; a read returns in the cycle after its address.
	always_ff @(posedge clk) begin
		if (state_q == lru_cache_pkg::ST_IDLE && in_valid) begin
			req_q <= in_data;
			ld_q  <= 64'd0;
		end
		if (rd_pend_q) begin
			ld_q[{3'(bcnt_q - 4'd1), 3'b000} +: 8] <= mem_rdata;
		end
	end

	a_out_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == lru_cache_pkg::ST_DONE)
		else $error("response shown outside done state");
	a_no_in_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lru_cache_pkg::ST_BYTES) |-> !in_ready)
		else $error("request taken while busy");
	a_store_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lru_cache_pkg::ST_BYTES && req_q.cmd) |=> !rd_pend_q)
		else $error("store issued a byte read");
endmodule
`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for lru_set_assoc_cache_write_through.
// Depends on lru_cache_pkg and the block itself; a local predictor checks every response.
`default_nettype none
module testbench;
	localparam int SETS = 1 << lru_cache_pkg::SET_BITS;
	localparam int MEM  = 1 << lru_cache_pkg::ADDR_BITS;
	localparam int CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	lru_cache_pkg::req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	lru_cache_pkg::rsp_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [4:0] cfg_data = '0;

	lru_set_assoc_cache_write_through u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// The clock runs with an 8 unit period.
	initial begin
		forever #4 clk = ~clk;
	end

	// Predictor state: a private copy of the configuration, tags, valid bits
	// and the backing memory.
	logic [2:0] mdl_log_block;
	logic [3:0] mdl_log_sets;
	logic [4:0] mdl_ways;
	logic [lru_cache_pkg::ADDR_BITS-1:0] mdl_tag [SETS][lru_cache_pkg::WAYS];
	logic mdl_vld [SETS][lru_cache_pkg::WAYS];
	logic [7:0] mdl_mem [MEM];

	lru_cache_pkg::rsp_t pending_rsp [$];
	int errors = 0;
	int cycles = 0;
	int loads_seen = 0, stores_seen = 0, hits_seen = 0;
	int send_idle = 0, recv_idle = 0;

	// Move the entry at way src (or a fresh tag) to the front of its set.
	function automatic void promote_way(int set_idx, int src,
			logic [lru_cache_pkg::ADDR_BITS-1:0] tg);
		for (int w = src; w > 0; w--) begin
			mdl_tag[set_idx][w] = mdl_tag[set_idx][w-1];
			mdl_vld[set_idx][w] = mdl_vld[set_idx][w-1];
		end
		mdl_tag[set_idx][0] = tg;
		mdl_vld[set_idx][0] = 1'b1;
	endfunction

	// Compute the response of one accepted request and update the copy of
	// the cache and memory state.
	function automatic lru_cache_pkg::rsp_t predict_access(lru_cache_pkg::req_t rq);
		int ls, nw, sz, set_idx;
		logic [lru_cache_pkg::ADDR_BITS-1:0] addr, tg, a;
		logic [63:0] ld;
		logic hit;
		lru_cache_pkg::rsp_t r;
		ls = (mdl_log_sets > lru_cache_pkg::SET_BITS) ? lru_cache_pkg::SET_BITS
			: mdl_log_sets;
		nw = (mdl_ways == 0) ? 1
			: ((mdl_ways > lru_cache_pkg::WAYS) ? lru_cache_pkg::WAYS : mdl_ways);
		sz = (rq.access_size > lru_cache_pkg::MAX_BYTES) ? lru_cache_pkg::MAX_BYTES
			: rq.access_size;
		addr = rq.address;
		tg = addr >> (mdl_log_block + ls);
		set_idx = (addr >> mdl_log_block) & ((1 << ls) - 1);
		hit = 1'b0;
		ld = '0;
		for (int w = 0; w < nw; w++) begin
			if (!hit && mdl_vld[set_idx][w] && mdl_tag[set_idx][w] == tg) begin
				hit = 1'b1;
				promote_way(set_idx, w, tg);
			end
		end
		if (!hit && !rq.cmd)
			promote_way(set_idx, nw - 1, tg);
		for (int t = 0; t < sz; t++) begin
			a = addr + t[lru_cache_pkg::ADDR_BITS-1:0];
			if (rq.cmd)
				mdl_mem[a] = rq.store_data[8*t +: 8];
			else
				ld[8*t +: 8] = mdl_mem[a];
		end
		r.was_store = rq.cmd;
		r.hit = hit;
		r.load_data = rq.cmd ? 64'd0 : ld;
		return r;
	endfunction

	// Directed rows: typed expectations only where they are obvious; the
	// rest are checked against the predictor.
	typedef struct {
		lru_cache_pkg::req_t rq;
		logic typed;
		lru_cache_pkg::rsp_t rs;
	} dir_row_t;
	dir_row_t dir_rows [$];

	task automatic add_row(logic c, logic [15:0] ad, logic [3:0] sz, logic [63:0] sd,
			logic typed, logic hit, logic [63:0] ld);
		dir_row_t d;
		d.rq = '{cmd: c, address: ad, access_size: sz, store_data: sd};
		d.typed = typed;
		d.rs = '{was_store: c, hit: hit, load_data: ld};
		dir_rows.push_back(d);
	endtask

	// A request goes out at the falling edge and is held until accepted.
	// Valid stays up after acceptance until the next request or an idle
	// cycle replaces it at a later falling edge.
	task automatic send_req(lru_cache_pkg::req_t rq);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= rq;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// A configuration write, issued only while no response is outstanding.
	task automatic write_cfg(logic [1:0] idx, logic [4:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			lru_cache_pkg::REG_LOG_BLOCK: mdl_log_block = val[2:0];
			lru_cache_pkg::REG_LOG_SETS:  mdl_log_sets = val[3:0];
			lru_cache_pkg::REG_WAYS:      mdl_ways = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain_wait();
		in_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic set_config(logic [2:0] lb, logic [3:0] lsets, logic [4:0] nw);
		drain_wait();
		write_cfg(lru_cache_pkg::REG_LOG_BLOCK, {2'b00, lb});
		write_cfg(lru_cache_pkg::REG_LOG_SETS, {1'b0, lsets});
		write_cfg(lru_cache_pkg::REG_WAYS, nw);
	endtask

	// Random requests are mostly confined to two small address windows, at
	// the bottom and top of memory, so that sets fill, hit and evict; a share roams the whole space.
	function automatic lru_cache_pkg::req_t random_req();
		lru_cache_pkg::req_t rq;
		rq.cmd = $urandom_range(2) == 0;
		if ($urandom_range(3) == 0)
			rq.address = 16'($urandom);
		else
			rq.address = 16'($urandom_range(511)) + ($urandom_range(1) ? 16'hFE00 : 16'h0);
		rq.access_size = ($urandom_range(15) < 12) ? 4'($urandom_range(8))
			: 4'($urandom_range(15));
		rq.store_data = {$urandom, $urandom};
		return rq;
	endfunction

	// Response checker: compare each accepted response with the oldest
	// expectation, field by field.
	always @(posedge clk) begin
		lru_cache_pkg::rsp_t exp_rsp;
		cycles <= cycles + 1;
		if (arst_n && out_valid && out_ready) begin
			if (pending_rsp.size() == 0) begin
				$error("response with no request outstanding");
				errors++;
			end else begin
				exp_rsp = pending_rsp.pop_front();
				if (out_data.was_store !== exp_rsp.was_store) begin
					$error("was_store: expected %0d actual %0d", exp_rsp.was_store,
						out_data.was_store);
					errors++;
				end
				if (out_data.hit !== exp_rsp.hit) begin
					$error("hit: expected %0d actual %0d", exp_rsp.hit, out_data.hit);
					errors++;
				end
				if (out_data.load_data !== exp_rsp.load_data) begin
					$error("load_data: expected %h actual %h", exp_rsp.load_data,
						out_data.load_data);
					errors++;
				end
				if (exp_rsp.was_store) stores_seen++; else loads_seen++;
				if (exp_rsp.hit) hits_seen++;
			end
		end
	end

	// Receiver: out_ready changes at the falling edge, idling at the rate
	// of the current phase.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	// A timeout ends a hung run.
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("lru_set_assoc_cache_write_through: mismatch");
			$finish;
		end
	end

	initial begin
		dir_row_t d;
		lru_cache_pkg::req_t rq;
		lru_cache_pkg::rsp_t r;
		for (int s = 0; s < SETS; s++)
			for (int w = 0; w < lru_cache_pkg::WAYS; w++) begin
				mdl_tag[s][w] = '0;
				mdl_vld[s][w] = 1'b0;
			end
		for (int i = 0; i < MEM; i++)
			mdl_mem[i] = 8'h00;
		mdl_log_block = 3'd5;
		mdl_log_sets = 4'd6;
		mdl_ways = 5'd4;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset configuration. A first load of
		// cleared memory misses and returns zero.
		add_row(1'b0, 16'h0000, 4'd8, 64'd0, 1'b1, 1'b0, 64'd0);
		add_row(1'b0, 16'h0000, 4'd8, 64'd0, 1'b1, 1'b1, 64'd0);
		// A store miss does not allocate, so the store after it misses too.
		add_row(1'b1, 16'h8000, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 64'd0);
		add_row(1'b1, 16'h8000, 4'd1, 64'h0, 1'b1, 1'b0, 64'd0);
		add_row(1'b0, 16'h8000, 4'd8, 64'd0, 1'b0, 1'b0, 64'd0);
		add_row(1'b1, 16'h8004, 4'd4, 64'h1234_5678_9ABC_DEF0, 1'b1, 1'b1, 64'd0);
		// Zero size returns zero data but still looks up the tags.
		add_row(1'b0, 16'h8000, 4'd0, 64'd0, 1'b1, 1'b1, 64'd0);
		// Sizes above the byte limit are clipped.
		add_row(1'b0, 16'h8000, 4'd15, 64'd0, 1'b0, 1'b0, 64'd0);
		// An access at the top of memory wraps to address zero.
		add_row(1'b1, 16'hFFFD, 4'd8, 64'hA5A5_0102_0304_0506, 1'b0, 1'b0, 64'd0);
		add_row(1'b0, 16'hFFFD, 4'd8, 64'd0, 1'b0, 1'b0, 64'd0);
		add_row(1'b0, 16'h0000, 4'd5, 64'd0, 1'b0, 1'b0, 64'd0);
		// Five tags in one set with four ways: the oldest is evicted.
		for (int k = 1; k <= 5; k++)
			add_row(1'b0, 16'(k << 11), 4'd2, 64'd0, 1'b0, 1'b0, 64'd0);
		add_row(1'b0, 16'h0800, 4'd2, 64'd0, 1'b0, 1'b0, 64'd0);
		add_row(1'b0, 16'h2800, 4'd2, 64'd0, 1'b0, 1'b0, 64'd0);
		foreach (dir_rows[i]) begin
			d = dir_rows[i];
			r = predict_access(d.rq);
			if (d.typed && r !== d.rs) begin
				$error("directed row %0d: table and predictor disagree", i);
				errors++;
			end
			pending_rsp.push_back(d.typed ? d.rs : r);
			send_req(d.rq);
		end

		// Random part: settings change between phases, including the
		// extremes and the out-of-range values that clip.
		for (int ph = 0; ph < 12; ph++) begin
			case (ph)
				0: set_config(3'd0, 4'd0, 5'd1);
				1: set_config(3'd7, 4'd10, 5'd16);
				2: set_config(3'd2, 4'd15, 5'd0);
				3: set_config(3'd3, 4'd2, 5'd31);
				4: set_config(3'd7, 4'd0, 5'd2);
				5: set_config(3'd0, 4'd10, 5'd17);
				default: set_config(3'($urandom_range(7)), 4'($urandom_range(15)),
					5'($urandom_range(31)));
			endcase
			if (ph < 4) begin
				send_idle = 10; recv_idle = 83;
			end else if (ph < 8) begin
				send_idle = 83; recv_idle = 10;
			end else begin
				send_idle = 0; recv_idle = 0;
			end
			for (int n = 0; n < 50; n++) begin
				rq = random_req();
				pending_rsp.push_back(predict_access(rq));
				send_req(rq);
			end
		end

		drain_wait();
		$display("Covered %0d loads and %0d stores, %0d of them hits, over 13 settings.",
			loads_seen, stores_seen, hits_seen);
		if (errors == 0)
			$display("lru_set_assoc_cache_write_through: match");
		else
			$display("lru_set_assoc_cache_write_through: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
